/* sv/bspb_pkg.sv */
// shared types, constants and helpers for the bit buffer
// no dependencies; imported by every module of the block

package bspb_pkg;

	localparam int WORD_BITS       = 64;
	localparam int FILL_BITS       = 6;
	localparam int NBITS_W         = 7;
	localparam int BITS_LEFT_W     = 15;
	localparam int STORE_WORDS_DEF = 256;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FLUSH = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic {
		BK_EXEC = 1'b0,
		BK_READ = 1'b1
	} back_state_t;

	// decoded word as it travels from front to back
	typedef struct packed {
		op_t                  op;
		logic [WORD_BITS-1:0] value;
		logic [NBITS_W-1:0]   n;
		logic                 zero;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	// ones in the low n bits, n up to 64
	function automatic logic [WORD_BITS-1:0] low_mask(input logic [NBITS_W-1:0] n);
		logic [WORD_BITS-1:0] m;
		if (n >= NBITS_W'(WORD_BITS)) begin
			m = '1;
		end else begin
			m = ~({WORD_BITS{1'b1}} << n);
		end
		return m;
	endfunction

endpackage

/* sv/bspb_front.sv */
// front end: accepts input words, clamps the width and masks the value
// depends on bspb_pkg; feeds bspb_queue

module bspb_front
	import bspb_pkg::*;
(
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic [WORD_BITS-1:0] value,
	input  logic [NBITS_W-1:0]   nbits,
	input  logic                 q_full,
	output push_t                push
);

	logic [NBITS_W-1:0] n_clamp;

	// widths above a full word count as a full word
	assign n_clamp = (nbits > NBITS_W'(WORD_BITS)) ? NBITS_W'(WORD_BITS) : nbits;

	assign in_stall        = q_full;
	assign push.push       = in_valid && !q_full;
	assign push.cmd.op     = op_t'(op);
	assign push.cmd.n      = n_clamp;
	assign push.cmd.zero   = (n_clamp == '0);
	assign push.cmd.value  = value & low_mask(n_clamp);

endmodule

/* sv/bspb_queue.sv */
// short command queue between front and back
// depends on bspb_pkg

module bspb_queue
	import bspb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output head_t head,
	output logic  full
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];
	assign do_push    = push.push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/bspb_back.sv */
// back end: bit counters, word store, field packing and unpacking, result register
// depends on bspb_pkg; pops commands from bspb_queue

module bspb_back
	import bspb_pkg::*;
#(
	parameter int STORE_WORDS = STORE_WORDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  head_t                  head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [WORD_BITS-1:0]   read_data,
	output logic                   error,
	output logic                   sticky_error,
	output logic [BITS_LEFT_W-1:0] bits_left
);

	localparam int LIMIT = STORE_WORDS * WORD_BITS;
	localparam int BW    = $clog2(LIMIT + 1);
	localparam int AW    = $clog2(STORE_WORDS);

	back_state_t state_q, state_d;

	logic [WORD_BITS-1:0] word_store_q [STORE_WORDS];
	logic [WORD_BITS-1:0] rd0_q, rd1_q;

	logic [WORD_BITS-1:0] acc_q, acc_d;
	logic [BW-1:0]        wused_q, wused_d;
	logic [BW-1:0]        committed_q, committed_d;
	logic [BW-1:0]        consumed_q, consumed_d;
	logic                 sticky_q, sticky_d;
	logic [NBITS_W-1:0]   rd_n_q, rd_n_d;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] read_data_q;
	logic                 error_q;
	logic                 sticky_out_q;
	logic [BITS_LEFT_W-1:0] bits_left_q;

	logic                   slot_free;
	logic                   load;
	logic [WORD_BITS-1:0]   res_data;
	logic                   res_err;
	logic                   mem_we;
	logic                   mem_re;
	logic [WORD_BITS-1:0]   mem_wdata;
	logic [AW-1:0]          waddr;
	logic [AW-1:0]          raddr0;
	logic [AW-1:0]          raddr1;
	logic [FILL_BITS-1:0]   wfill;
	logic [FILL_BITS-1:0]   roff;
	logic [2*WORD_BITS-1:0] wshift;
	logic [2*WORD_BITS-1:0] rwin;
	logic [NBITS_W-1:0]     fsum;
	logic [BW-1:0]          wsum;
	logic                   over;
	logic [BW-1:0]          unread;
	logic [WORD_BITS-1:0]   rd_field;

	assign wfill  = wused_q[FILL_BITS-1:0];
	assign roff   = consumed_q[FILL_BITS-1:0];
	assign waddr  = wused_q[FILL_BITS +: AW];
	assign raddr0 = consumed_q[FILL_BITS +: AW];
	assign raddr1 = (raddr0 == AW'(STORE_WORDS - 1)) ? '0 : raddr0 + 1'b1;

	// new field lands at the fill offset; the upper half is the spill into the next word
	assign wshift = {{WORD_BITS{1'b0}}, head.cmd.value} << wfill;
	assign fsum   = {1'b0, wfill} + head.cmd.n;
	assign wsum   = wused_q + BW'(head.cmd.n);
	assign over   = ({1'b0, wused_q} + (BW + 1)'(head.cmd.n)) > (BW + 1)'(LIMIT);
	assign unread = committed_q - consumed_q;

	assign rwin     = {rd1_q, rd0_q} >> roff;
	assign rd_field = rwin[WORD_BITS-1:0] & low_mask(rd_n_q);

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_EXEC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		load        = 1'b0;
		res_data    = '0;
		res_err     = 1'b0;
		acc_d       = acc_q;
		wused_d     = wused_q;
		committed_d = committed_q;
		consumed_d  = consumed_q;
		sticky_d    = sticky_q;
		rd_n_d      = rd_n_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_wdata   = acc_q;
		case (state_q)
			BK_EXEC: begin
				if (head.valid && slot_free) begin
					pop = 1'b1;
					case (head.cmd.op)
						OP_WRITE: begin
							load = 1'b1;
							if (!head.cmd.zero) begin
								if (over) begin
									res_err  = 1'b1;
									sticky_d = 1'b1;
								end else begin
									wused_d = wsum;
									if (fsum[NBITS_W-1]) begin
										mem_we      = 1'b1;
										mem_wdata   = acc_q | wshift[WORD_BITS-1:0];
										acc_d       = wshift[2*WORD_BITS-1:WORD_BITS];
										committed_d = {wsum[BW-1:FILL_BITS], {FILL_BITS{1'b0}}};
									end else begin
										acc_d = acc_q | wshift[WORD_BITS-1:0];
									end
								end
							end
						end
						OP_FLUSH: begin
							load = 1'b1;
							if (wfill != '0) begin
								mem_we      = 1'b1;
								committed_d = wused_q;
							end
						end
						OP_READ: begin
							if (head.cmd.zero) begin
								load = 1'b1;
							end else if (BW'(head.cmd.n) > unread) begin
								load     = 1'b1;
								res_err  = 1'b1;
								sticky_d = 1'b1;
							end else begin
								mem_re  = 1'b1;
								rd_n_d  = head.cmd.n;
								state_d = BK_READ;
							end
						end
						OP_CLEAR: begin
							load        = 1'b1;
							acc_d       = '0;
							wused_d     = '0;
							committed_d = '0;
							consumed_d  = '0;
							sticky_d    = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			BK_READ: begin
				load       = 1'b1;
				res_data   = rd_field;
				consumed_d = consumed_q + BW'(rd_n_q);
				state_d    = BK_EXEC;
			end
			default: begin
				state_d = BK_EXEC;
			end
		endcase
	end

	// word store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			word_store_q[waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd0_q <= word_store_q[raddr0];
			rd1_q <= word_store_q[raddr1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			wused_q     <= '0;
			committed_q <= '0;
			consumed_q  <= '0;
			sticky_q    <= 1'b0;
			rd_n_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			acc_q       <= acc_d;
			wused_q     <= wused_d;
			committed_q <= committed_d;
			consumed_q  <= consumed_d;
			sticky_q    <= sticky_d;
			rd_n_q      <= rd_n_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			read_data_q  <= res_data;
			error_q      <= res_err;
			sticky_out_q <= sticky_d;
			bits_left_q  <= BITS_LEFT_W'(committed_d - consumed_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign error        = error_q;
	assign sticky_error = sticky_out_q;
	assign bits_left    = bits_left_q;

	a_read_behind_commit: assert property (@(posedge clk) disable iff (!arst_n)
		consumed_q <= committed_q)
		else $error("read position passed committed bits");

	a_commit_behind_write: assert property (@(posedge clk) disable iff (!arst_n)
		committed_q <= wused_q)
		else $error("committed bits exceed written bits");

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wused_q <= BW'(LIMIT))
		else $error("write position beyond store");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_READ |-> !out_valid_q)
		else $error("read finishing while result slot occupied");

	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store written and read in one cycle");

endmodule

/* sv/bitstream_pack_unpack_buffer.sv */
// top level of the bit buffer: front end, command queue and back end
// depends on bspb_pkg, bspb_front, bspb_queue, bspb_back
// result path: queue, then result register; reads pass the store read registers in between
// throughput: one word per cycle unless stalled; a read adds an align state after store read
// reset: arst_n clears queue, bit counters, accumulator and flags; store contents stay
// undefined and need no clearing pass since only committed words are ever read

module bitstream_pack_unpack_buffer
	import bspb_pkg::*;
#(
	parameter int STORE_WORDS = STORE_WORDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input words
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             op,
	input  logic [WORD_BITS-1:0]   value,
	input  logic [NBITS_W-1:0]     nbits,
	// result words
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [WORD_BITS-1:0]   read_data,
	output logic                   error,
	output logic                   sticky_error,
	output logic [BITS_LEFT_W-1:0] bits_left
);

	// front to queue: decoded word, masked value and clamped width
	push_t push;
	// queue to back: head of queue
	head_t head;
	logic  q_full;
	logic  pop;

	// front end stalls only on a full queue, so it keeps taking words
	// while the back end waits on a stalled result
	bspb_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.value    (value),
		.nbits    (nbits),
		.q_full   (q_full),
		.push     (push)
	);

	// two-entry queue decouples the input stall from the back end
	bspb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (q_full)
	);

	// back end owns all buffer state and the word store; the result
	// register parts it from the output side
	bspb_back #(
		.STORE_WORDS (STORE_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.error        (error),
		.sticky_error (sticky_error),
		.bits_left    (bits_left)
	);

endmodule
